// ===== src/lzw_chunk_decoder_defines.svh =====
// assertion macros for the lzw chunk decoder
// used by the top level; expects clk and rst in scope
`ifndef LZW_CHUNK_DECODER_DEFINES_SVH
`define LZW_CHUNK_DECODER_DEFINES_SVH

// same-cycle implication
`define LCD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lcd_pkg.sv =====
// shared types and constants of the lzw chunk decoder
// no dependencies
`default_nettype none

package lcd_pkg;

  localparam int TABLE_ENTRIES    = 4096;
  localparam int ADDR_W           = $clog2(TABLE_ENTRIES);
  localparam int CODE_W           = 12;
  localparam int BYTES_PER_RESULT = 64;
  localparam int SLOT_W           = $clog2(BYTES_PER_RESULT);
  localparam int CNT_W            = $clog2(BYTES_PER_RESULT + 1);
  localparam int PEND_W           = BYTES_PER_RESULT * 8;
  localparam int LEN_W            = 28;
  localparam int BUF_W            = 20;
  localparam int HELD_W           = 5;
  localparam int WIDTH_W          = 4;
  localparam int STAT_W           = 3;
  localparam int PADDR_W          = 3;

  localparam logic [CODE_W-1:0]  FIRST_FREE  = 12'h100;
  localparam logic [CODE_W-1:0]  LAST_FREE   = 12'hfff;
  localparam logic [CODE_W-1:0]  LIT_MAX     = 12'h0ff;
  localparam logic [LEN_W-1:0]   MAX_LENGTH  = 28'h800_0000;
  localparam logic [WIDTH_W-1:0] START_WIDTH = 4'd9;
  localparam logic [WIDTH_W-1:0] MAX_WIDTH   = 4'd12;

  // register index of output_length
  localparam logic REG_OUTPUT_LENGTH = 1'b0;

  localparam logic [STAT_W-1:0] ST_DATA        = 3'd0;
  localparam logic [STAT_W-1:0] ST_DONE        = 3'd1;
  localparam logic [STAT_W-1:0] ST_BAD_CODE    = 3'd2;
  localparam logic [STAT_W-1:0] ST_SHORT_INPUT = 3'd3;
  localparam logic [STAT_W-1:0] ST_OVERRUN     = 3'd4;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       final_byte;
  } byte_item_t;

  typedef struct packed {
    logic [63:0]       data_7;
    logic [63:0]       data_6;
    logic [63:0]       data_5;
    logic [63:0]       data_4;
    logic [63:0]       data_3;
    logic [63:0]       data_2;
    logic [63:0]       data_1;
    logic [63:0]       data_0;
    logic [CNT_W-1:0]  byte_count;
    logic              run_end;
    logic [STAT_W-1:0] status;
  } result_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EXTRACT, S_DECODE, S_CHAIN, S_FETCH, S_LEAF, S_CHECK,
    S_POP_REQ, S_POP, S_UPDATE, S_POST, S_FLUSH, S_FIN
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_EXTRACT, OP_FIRST_LIT, OP_LIT, OP_CHAIN, OP_FETCH_REQ,
    OP_FETCH, OP_LEAF, OP_CHECK, OP_POP_REQ, OP_POP, OP_UPDATE, OP_POST, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic [STAT_W-1:0] status;
    logic              last;
  } dp_cmd_t;

  typedef struct packed {
    logic finished;
    logic len_over;
    logic br_zero;
    logic have_code;
    logic final_flag;
    logic expect_lit;
    logic code_gt_ff;
    logic code_lt_free;
    logic code_gt_nf;
    logic c_gt_ff;
    logic pref_gt_ff;
    logic n_gt_br;
    logic n_zero;
    logic pend_full;
    logic pend_any;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/lcd_dp.sv =====
// datapath of the lzw chunk decoder: bit unpacker, dictionary, string stack,
// result packer and output register; uses lcd_pkg
`default_nettype none

module lcd_dp
  import lcd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [LEN_W-1:0]   cfg_value,
  input  wire byte_item_t         byte_item,
  input  wire dp_cmd_t            cmd,
  input  wire logic               result_ready,
  output logic                    result_valid,
  output result_item_t            result_item,
  output logic [LEN_W-1:0]        output_length,
  output dp_stat_t                stat
);

  logic [BUF_W-1:0]   bit_buffer;
  logic [HELD_W-1:0]  bits_held;
  logic [WIDTH_W-1:0] code_width;
  logic [CODE_W-1:0]  next_free;
  logic [CODE_W-1:0]  prev_code;
  logic [7:0]         first_char;
  logic [LEN_W-1:0]   bytes_left;
  logic               expect_lit;
  logic               finished;
  logic               final_flag;
  logic [CODE_W-1:0]  code;
  logic [CODE_W-1:0]  chain;
  logic [ADDR_W-1:0]  depth;
  logic [7:0]         last_char;
  logic [PEND_W-1:0]  pend;
  logic [CNT_W-1:0]   pend_cnt;

  logic [CODE_W-1:0]  prefix_mem [TABLE_ENTRIES];
  logic [7:0]         suffix_mem [TABLE_ENTRIES];
  logic [7:0]         stack_mem  [TABLE_ENTRIES];
  logic [CODE_W-1:0]  prefix_rd;
  logic [7:0]         suffix_rd;
  logic [7:0]         stack_rd;

  logic               tab_re;
  logic [ADDR_W-1:0]  tab_raddr;
  logic               tab_we;
  logic               stack_we;
  logic [ADDR_W-1:0]  stack_waddr;
  logic [7:0]         stack_wdata;
  logic               stack_re;
  logic [ADDR_W-1:0]  stack_raddr;
  logic               put_en;
  logic [7:0]         put_data;
  logic               out_load;

  logic [HELD_W-1:0]  shift_amt;
  logic [BUF_W-1:0]   shifted;
  logic [CODE_W-1:0]  code_mask;
  logic               grow;

  function automatic result_item_t pack_result(input logic [PEND_W-1:0] bytes,
                                               input logic [CNT_W-1:0] cnt,
                                               input logic run_end,
                                               input logic [STAT_W-1:0] status);
    result_item_t r;
    r.data_0     = bytes[63:0];
    r.data_1     = bytes[127:64];
    r.data_2     = bytes[191:128];
    r.data_3     = bytes[255:192];
    r.data_4     = bytes[319:256];
    r.data_5     = bytes[383:320];
    r.data_6     = bytes[447:384];
    r.data_7     = bytes[511:448];
    r.byte_count = cnt;
    r.run_end    = run_end;
    r.status     = status;
    return r;
  endfunction

  assign shift_amt = bits_held - HELD_W'(code_width);
  assign shifted   = bit_buffer >> shift_amt;
  assign code_mask = ~({CODE_W{1'b1}} << code_width);
  assign grow      = ((13'(next_free) + 13'd2) == (13'd1 << code_width))
                     && (code_width < MAX_WIDTH);

  // output register takes a result on an emit or on a put into a full packer
  assign out_load  = (cmd.op == OP_EMIT)
                     || (put_en && (pend_cnt == CNT_W'(BYTES_PER_RESULT)));

  always_comb begin
    stat.finished     = finished;
    stat.len_over     = output_length > MAX_LENGTH;
    stat.br_zero      = bytes_left == '0;
    stat.have_code    = bits_held >= HELD_W'(code_width);
    stat.final_flag   = final_flag;
    stat.expect_lit   = expect_lit;
    stat.code_gt_ff   = code > LIT_MAX;
    stat.code_lt_free = code < FIRST_FREE;
    stat.code_gt_nf   = code > next_free;
    stat.c_gt_ff      = chain > LIT_MAX;
    stat.pref_gt_ff   = prefix_rd > LIT_MAX;
    stat.n_gt_br      = LEN_W'(depth) > bytes_left;
    stat.n_zero       = depth == '0;
    stat.pend_full    = pend_cnt == CNT_W'(BYTES_PER_RESULT);
    stat.pend_any     = pend_cnt != '0;
    stat.out_free     = !result_valid || result_ready;
  end

  // memory port selection
  always_comb begin
    tab_re      = 1'b0;
    tab_raddr   = ADDR_W'(chain);
    tab_we      = 1'b0;
    stack_we    = 1'b0;
    stack_waddr = depth;
    stack_wdata = suffix_rd;
    stack_re    = 1'b0;
    stack_raddr = depth - 1'b1;
    put_en      = 1'b0;
    put_data    = code[7:0];
    unique case (cmd.op)
      OP_FIRST_LIT, OP_LIT: put_en = 1'b1;
      OP_CHAIN: begin
        if (code == next_free) begin
          stack_we    = 1'b1;
          stack_waddr = '0;
          stack_wdata = first_char;
        end
      end
      OP_FETCH_REQ: tab_re = 1'b1;
      OP_FETCH: begin
        stack_we  = 1'b1;
        tab_re    = 1'b1;
        tab_raddr = ADDR_W'(prefix_rd);
      end
      OP_LEAF: begin
        stack_we    = 1'b1;
        stack_wdata = chain[7:0];
      end
      OP_POP_REQ: stack_re = 1'b1;
      OP_POP: begin
        put_en   = 1'b1;
        put_data = stack_rd;
        stack_re = depth != '0;
      end
      OP_UPDATE: tab_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      prefix_mem[ADDR_W'(next_free)] <= prev_code;
      suffix_mem[ADDR_W'(next_free)] <= last_char;
    end
    if (tab_re) begin
      prefix_rd <= prefix_mem[tab_raddr];
      suffix_rd <= suffix_mem[tab_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= stack_wdata;
    end
    if (stack_re) begin
      stack_rd <= stack_mem[stack_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      output_length <= '0;
      bit_buffer    <= '0;
      bits_held     <= '0;
      code_width    <= START_WIDTH;
      next_free     <= FIRST_FREE;
      prev_code     <= '0;
      first_char    <= '0;
      bytes_left    <= '0;
      expect_lit    <= 1'b1;
      finished      <= 1'b0;
      final_flag    <= 1'b0;
      depth         <= '0;
      pend          <= '0;
      pend_cnt      <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if (cfg_we) begin
        output_length <= cfg_value;
        bit_buffer    <= '0;
        bits_held     <= '0;
        code_width    <= START_WIDTH;
        next_free     <= FIRST_FREE;
        prev_code     <= '0;
        first_char    <= '0;
        bytes_left    <= cfg_value;
        expect_lit    <= 1'b1;
        finished      <= 1'b0;
      end
      unique case (cmd.op)
        OP_LOAD: begin
          bit_buffer <= {bit_buffer[BUF_W-9:0], byte_item.packed_byte};
          bits_held  <= bits_held + HELD_W'(8);
          final_flag <= byte_item.final_byte;
        end
        OP_EXTRACT: begin
          code      <= shifted[CODE_W-1:0] & code_mask;
          bits_held <= shift_amt;
        end
        OP_FIRST_LIT: begin
          bytes_left <= bytes_left - 1'b1;
          first_char <= code[7:0];
          prev_code  <= code;
          next_free  <= FIRST_FREE;
          expect_lit <= 1'b0;
        end
        OP_LIT: begin
          bytes_left <= bytes_left - 1'b1;
          last_char  <= code[7:0];
        end
        OP_CHAIN: begin
          if (code == next_free) begin
            depth <= ADDR_W'(1);
            chain <= prev_code;
          end else begin
            depth <= '0;
            chain <= code;
          end
        end
        OP_FETCH: begin
          depth <= depth + 1'b1;
          chain <= prefix_rd;
        end
        OP_LEAF: begin
          depth     <= depth + 1'b1;
          last_char <= chain[7:0];
        end
        OP_CHECK: bytes_left <= bytes_left - LEN_W'(depth);
        OP_POP_REQ: depth <= depth - 1'b1;
        OP_POP: begin
          if (depth != '0) begin
            depth <= depth - 1'b1;
          end
        end
        OP_UPDATE: begin
          next_free  <= next_free + 1'b1;
          first_char <= last_char;
          prev_code  <= code;
          if (grow) begin
            code_width <= code_width + 1'b1;
          end
        end
        OP_POST: begin
          // dictionary full: restart, next code must be a literal
          if (next_free == LAST_FREE) begin
            expect_lit <= 1'b1;
            code_width <= START_WIDTH;
          end
        end
        OP_EMIT: begin
          result_item  <= pack_result(pend, pend_cnt, cmd.last, cmd.status);
          pend         <= '0;
          pend_cnt     <= '0;
          if (cmd.status != ST_DATA) begin
            finished <= 1'b1;
          end
        end
        default: ;
      endcase
      if (put_en) begin
        if (pend_cnt == CNT_W'(BYTES_PER_RESULT)) begin
          // full result leaves before the new byte goes in
          result_item  <= pack_result(pend, pend_cnt, 1'b0, ST_DATA);
          pend         <= PEND_W'(put_data);
          pend_cnt     <= CNT_W'(1);
        end else begin
          pend[8*pend_cnt[SLOT_W-1:0] +: 8] <= put_data;
          pend_cnt <= pend_cnt + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/lcd_ctrl.sv =====
// controller of the lzw chunk decoder: sequences code extraction, chain walk,
// string output and dictionary update; uses lcd_pkg
`default_nettype none

module lcd_ctrl
  import lcd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     byte_valid,
  output logic          byte_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  ctrl_state_t       state;
  ctrl_state_t       state_next;
  logic [STAT_W-1:0] fin_status;
  logic [STAT_W-1:0] fin_status_next;
  logic              can_put;

  assign can_put    = !stat.pend_full || stat.out_free;
  assign byte_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fin_status <= ST_DATA;
    end else begin
      state      <= state_next;
      fin_status <= fin_status_next;
    end
  end

  always_comb begin
    state_next      = state;
    fin_status_next = fin_status;
    cmd.op          = OP_NONE;
    cmd.status      = ST_DATA;
    cmd.last        = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (byte_valid) begin
          priority if (stat.finished) begin
            state_next = S_IDLE;
          end else if (stat.len_over) begin
            fin_status_next = ST_OVERRUN;
            state_next      = S_FIN;
          end else if (stat.br_zero) begin
            fin_status_next = ST_DONE;
            state_next      = S_FIN;
          end else begin
            cmd.op     = OP_LOAD;
            state_next = S_EXTRACT;
          end
        end
      end
      S_EXTRACT: begin
        priority if (stat.have_code) begin
          cmd.op     = OP_EXTRACT;
          state_next = S_DECODE;
        end else if (stat.final_flag) begin
          fin_status_next = ST_SHORT_INPUT;
          state_next      = S_FIN;
        end else if (stat.pend_any) begin
          state_next = S_FLUSH;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DECODE: begin
        priority if (stat.expect_lit && stat.code_gt_ff) begin
          fin_status_next = ST_BAD_CODE;
          state_next      = S_FIN;
        end else if (stat.expect_lit) begin
          if (can_put) begin
            cmd.op     = OP_FIRST_LIT;
            state_next = S_POST;
          end
        end else if (stat.code_lt_free) begin
          if (can_put) begin
            cmd.op     = OP_LIT;
            state_next = S_UPDATE;
          end
        end else if (stat.code_gt_nf) begin
          fin_status_next = ST_BAD_CODE;
          state_next      = S_FIN;
        end else begin
          cmd.op     = OP_CHAIN;
          state_next = S_CHAIN;
        end
      end
      S_CHAIN: begin
        if (stat.c_gt_ff) begin
          cmd.op     = OP_FETCH_REQ;
          state_next = S_FETCH;
        end else begin
          state_next = S_LEAF;
        end
      end
      S_FETCH: begin
        cmd.op = OP_FETCH;
        if (!stat.pref_gt_ff) begin
          state_next = S_LEAF;
        end
      end
      S_LEAF: begin
        cmd.op     = OP_LEAF;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.n_gt_br) begin
          fin_status_next = ST_OVERRUN;
          state_next      = S_FIN;
        end else begin
          cmd.op     = OP_CHECK;
          state_next = S_POP_REQ;
        end
      end
      S_POP_REQ: begin
        cmd.op     = OP_POP_REQ;
        state_next = S_POP;
      end
      S_POP: begin
        if (can_put) begin
          cmd.op = OP_POP;
          if (stat.n_zero) begin
            state_next = S_UPDATE;
          end
        end
      end
      S_UPDATE: begin
        cmd.op     = OP_UPDATE;
        state_next = S_POST;
      end
      S_POST: begin
        if (stat.br_zero) begin
          fin_status_next = ST_DONE;
          state_next      = S_FIN;
        end else begin
          cmd.op     = OP_POST;
          state_next = S_EXTRACT;
        end
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          cmd.op     = OP_EMIT;
          cmd.status = ST_DATA;
          state_next = S_IDLE;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.op     = OP_EMIT;
          cmd.status = fin_status;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/lzw_chunk_decoder.sv =====
// top level of the lzw chunk decoder: register port, controller and datapath
// uses lcd_pkg, lcd_ctrl, lcd_dp and lzw_chunk_decoder_defines.svh
//
// usage:
// - write output_length (byte address 0) to start a chunk; this clears the
//   bit unpacker, code width (9), next free code (0x100) and the done flag
// - feed compressed bytes on byte_valid/byte_ready, one per transfer, with
//   final_byte set on the last one; a byte is taken only in the idle state
// - decoded bytes leave on result_valid/result_ready in results of up to 64
//   bytes; run_end marks the last result caused by one input byte, and only
//   that result may carry a nonzero status (done, bad code, short input,
//   overrun); after a status the block swallows input silently until the
//   next output_length write
// - each input byte is loaded, then each code it completes is extracted and
//   decoded; a literal then takes update and post (the first code of a pass
//   skips update), other codes also walk the chain, write the leaf, check
//   the length and pop the string stack; chain walk and string stack each
//   move one entry a cycle, the stack pop only while the packer or output
//   register can take the byte
// - the result register frees the decoder from the receiver: a stalled
//   receiver holds the decoder only once a second result is ready to leave
// - reset (rst, synchronous) returns to idle with output_length 0, so the
//   first byte after reset completes at once
`default_nettype none
`include "lzw_chunk_decoder_defines.svh"

module lzw_chunk_decoder
  import lcd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // register port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  // compressed bytes in
  input  wire logic               byte_valid,
  output logic                    byte_ready,
  input  wire byte_item_t         byte_item,
  // decoded results out
  output logic                    result_valid,
  input  wire logic               result_ready,
  output result_item_t            result_item
);

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic             cfg_we;
  logic [LEN_W-1:0] output_length;

  // single register; writes beyond it are dropped
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_OUTPUT_LENGTH);
  assign prdata = (paddr[2] == REG_OUTPUT_LENGTH) ? 32'(output_length) : '0;

  // sequencer: decides each cycle's datapath operation
  lcd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // unpacker, dictionary, stack and result register
  lcd_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_value     (pwdata[LEN_W-1:0]),
    .byte_item     (byte_item),
    .cmd           (cmd),
    .result_ready  (result_ready),
    .result_valid  (result_valid),
    .result_item   (result_item),
    .output_length (output_length),
    .stat          (stat)
  );

  // a status only ever closes a run
  `LCD_ASSERT_IMP(a_status_last, result_valid && (result_item.status != ST_DATA), result_item.run_end, "status on a result that does not end its run")

  // results that do not end a run are full
  `LCD_ASSERT_IMP(a_full_mid, result_valid && !result_item.run_end, result_item.byte_count == CNT_W'(BYTES_PER_RESULT), "partial result in the middle of a run")

  // byte count never exceeds the slots
  `LCD_ASSERT_IMP(a_count_range, result_valid, result_item.byte_count <= CNT_W'(BYTES_PER_RESULT), "byte count beyond result size")

  // after a closing status transfer the decoder sits idle
  `LCD_ASSERT_NEXT(a_idle_after_end, result_valid && result_ready && (result_item.status != ST_DATA), byte_ready, "decoder busy after chunk end")

endmodule

`default_nettype wire

// ===== tb/sv/lcd_result_checker.sv =====
// result checker for the lzw chunk decoder: predicts decoded results and compares them
// depends on lcd_pkg; watches the register port and both handshake channels
`timescale 1ns / 100ps

module lcd_result_checker
  import lcd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic               pready,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  input  wire logic               byte_valid,
  input  wire logic               byte_ready,
  input  wire byte_item_t         byte_item,
  input  wire logic               result_valid,
  input  wire logic               result_ready,
  input  wire result_item_t       result_item,
  output int                      mismatches,
  output int                      pending
);

  // predictor copy of the register and the decoder state
  logic [LEN_W-1:0] chunk_len;
  logic [11:0]      prefix_mem [TABLE_ENTRIES];
  logic [7:0]       suffix_mem [TABLE_ENTRIES];
  logic [7:0]       string_stack [TABLE_ENTRIES];
  logic [BUF_W-1:0] bit_acc;
  int               acc_bits;
  int               code_bits;
  int               free_code;
  int               last_code;
  int               lead_char;
  int               bytes_left;
  bit               need_literal;
  int               chunk_state;   // 0 running, 1 complete, 2 error

  logic [7:0]       out_bytes [BYTES_PER_RESULT];
  int               out_count;
  result_item_t     decoded_q [$];

  function automatic void restart_chunk();
    bit_acc      = '0;
    acc_bits     = 0;
    code_bits    = START_WIDTH;
    free_code    = FIRST_FREE;
    last_code    = 0;
    lead_char    = 0;
    bytes_left   = chunk_len;
    need_literal = 1;
    chunk_state  = 0;
  endfunction

  function automatic void push_result(logic [STAT_W-1:0] st, bit last);
    logic [PEND_W-1:0] flat;
    result_item_t      r;
    flat = '0;
    for (int i = 0; i < out_count; i++) flat[8*i +: 8] = out_bytes[i];
    r.data_0     = flat[63:0];
    r.data_1     = flat[127:64];
    r.data_2     = flat[191:128];
    r.data_3     = flat[255:192];
    r.data_4     = flat[319:256];
    r.data_5     = flat[383:320];
    r.data_6     = flat[447:384];
    r.data_7     = flat[511:448];
    r.byte_count = CNT_W'(out_count);
    r.run_end    = last;
    r.status     = st;
    decoded_q.push_back(r);
    out_count = 0;
  endfunction

  function automatic void put_out(int b);
    if (out_count >= BYTES_PER_RESULT) push_result(ST_DATA, 0);
    out_bytes[out_count] = b[7:0];
    out_count++;
  endfunction

  // one code through the dictionary; returns a terminal status or data
  function automatic logic [STAT_W-1:0] decode_code(int code);
    int  n;
    int  c;
    int  tail;
    bit  grow;
    if (need_literal) begin
      if (code > int'(LIT_MAX)) return ST_BAD_CODE;
      put_out(code);
      bytes_left--;
      lead_char    = code;
      last_code    = code;
      free_code    = FIRST_FREE;
      need_literal = 0;
    end else begin
      if (code < int'(FIRST_FREE)) begin
        put_out(code);
        bytes_left--;
        tail = code;
      end else begin
        n = 0;
        c = code;
        if (c >= free_code) begin
          // code one past the table: previous string plus its own first char
          if (c > free_code) return ST_BAD_CODE;
          string_stack[n] = lead_char[7:0];
          n++;
          c = last_code;
        end
        while (c > int'(LIT_MAX)) begin
          if (c >= TABLE_ENTRIES || n >= TABLE_ENTRIES) return ST_BAD_CODE;
          string_stack[n] = suffix_mem[c];
          n++;
          c = prefix_mem[c];
        end
        if (n >= TABLE_ENTRIES) return ST_BAD_CODE;
        string_stack[n] = c[7:0];
        n++;
        tail = c;
        if (n > bytes_left) return ST_OVERRUN;
        bytes_left -= n;
        for (int i = n; i > 0; i--) put_out(string_stack[i-1]);
      end
      if (free_code < TABLE_ENTRIES) begin
        prefix_mem[free_code] = last_code[11:0];
        suffix_mem[free_code] = tail[7:0];
      end
      grow      = (free_code + 2) == (1 << code_bits);
      free_code = (free_code + 1) & 'hfff;
      lead_char = tail & 'hff;
      last_code = code & 'hfff;
      if (grow && code_bits < int'(MAX_WIDTH)) code_bits++;
    end
    if (bytes_left == 0) return ST_DONE;
    if (free_code == int'(LAST_FREE)) begin
      // dictionary full: start over at 9 bits with a literal
      need_literal = 1;
      code_bits    = START_WIDTH;
    end
    return ST_DATA;
  endfunction

  function automatic void accept_byte(byte_item_t it);
    logic [STAT_W-1:0] st;
    int                code;
    if (chunk_state != 0) return;
    out_count = 0;
    st = ST_DATA;
    if (chunk_len > MAX_LENGTH) begin
      st = ST_OVERRUN;
    end else if (bytes_left == 0) begin
      st = ST_DONE;
    end else begin
      bit_acc  = {bit_acc[BUF_W-9:0], it.packed_byte};
      acc_bits += 8;
      while (st == ST_DATA && acc_bits >= code_bits) begin
        code = int'(bit_acc >> (acc_bits - code_bits)) & ((1 << code_bits) - 1);
        acc_bits -= code_bits;
        st = decode_code(code);
      end
      if (st == ST_DATA && it.final_byte) st = ST_SHORT_INPUT;
    end
    if (st != ST_DATA) begin
      chunk_state = (st == ST_DONE) ? 1 : 2;
      push_result(st, 1);
    end else if (out_count > 0) begin
      push_result(ST_DATA, 1);
    end
  endfunction

  function automatic void check_field(string nm, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, nm, want, got);
    end
  endfunction

  function automatic void check_result(result_item_t got);
    result_item_t want;
    if (decoded_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("%0t: result with nothing expected", $realtime);
      return;
    end
    want = decoded_q.pop_front();
    check_field("data_0", want.data_0, got.data_0);
    check_field("data_1", want.data_1, got.data_1);
    check_field("data_2", want.data_2, got.data_2);
    check_field("data_3", want.data_3, got.data_3);
    check_field("data_4", want.data_4, got.data_4);
    check_field("data_5", want.data_5, got.data_5);
    check_field("data_6", want.data_6, got.data_6);
    check_field("data_7", want.data_7, got.data_7);
    check_field("byte_count", 64'(want.byte_count), 64'(got.byte_count));
    check_field("run_end", 64'(want.run_end), 64'(got.run_end));
    check_field("status", 64'(want.status), 64'(got.status));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      chunk_len  = '0;
      mismatches = 0;
      restart_chunk();
      decoded_q.delete();
    end else begin
      if (result_valid && result_ready) check_result(result_item);
      if (psel && penable && pwrite && pready &&
          paddr[PADDR_W-1:2] == REG_OUTPUT_LENGTH) begin
        chunk_len = pwdata[LEN_W-1:0];
        restart_chunk();
      end
      if (byte_valid && byte_ready) accept_byte(byte_item);
    end
    pending = decoded_q.size();
  end

endmodule

// ===== tb/sv/lzw_chunk_decoder_tb.sv =====
// top of the lzw chunk decoder testbench: clock, reset, stimulus and verdict
// depends on lcd_pkg, lzw_chunk_decoder and lcd_result_checker
`timescale 1ns / 100ps

module lzw_chunk_decoder_tb;
  import lcd_pkg::*;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int SETTLE      = 100;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               byte_valid;
  logic               byte_ready;
  byte_item_t         byte_item;
  logic               result_valid;
  logic               result_ready;
  result_item_t       result_item;
  int                 mismatches;
  int                 pending;

  // flags shared between the sender and the receiver, and the sent byte count
  bit fast;             // no idling on either side for this chunk
  bit long_stall_req;   // receiver holds off for a long stretch
  int bytes_sent;

  // code stream builder state, mirrors the dictionary growth and decoded length
  int gen_free;
  int gen_bits;
  bit gen_literal;
  int gen_prev;
  int gen_total;
  int str_len [TABLE_ENTRIES];
  int code_q [$];
  int bits_q [$];

  lzw_chunk_decoder i_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

  lcd_result_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // run guard
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("lzw_chunk_decoder_tb: FAIL");
    $finish;
  end

  // receiver: random wait per result, plus one long hold-off on request
  initial begin : receiver
    int rx_wait;
    int rx_hold;
    rx_wait      = 0;
    rx_hold      = 0;
    result_ready = 0;
    forever begin
      @(posedge clk);
      if (long_stall_req) begin
        long_stall_req = 0;
        rx_hold        = 400;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        result_ready <= 0;
      end else if (result_ready && result_valid) begin
        // transfer done, draw the wait before the next one
        rx_wait = fast ? 0 : $urandom_range(0, 13);
        result_ready <= (rx_wait == 0);
      end else if (!result_ready) begin
        if (rx_wait > 0) rx_wait--;
        else result_ready <= 1;
      end
    end
  end

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] value);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
  endtask

  // valid stays high across back-to-back transfers
  task automatic send_byte(input logic [7:0] b, input bit fin);
    int gap;
    gap = fast ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      byte_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    byte_valid            <= 1;
    byte_item.packed_byte <= b;
    byte_item.final_byte  <= fin;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // wait until every decoded result is back, then let the block settle
  task automatic drain();
    byte_valid <= 0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic gen_reset();
    gen_free     = FIRST_FREE;
    gen_bits     = START_WIDTH;
    gen_literal  = 1;
    gen_prev     = 0;
    gen_total    = 0;
    code_q.delete();
    bits_q.delete();
  endtask

  function automatic int len_of(int c);
    return (c < int'(FIRST_FREE)) ? 1 : str_len[c];
  endfunction

  // append a legal code and track dictionary growth and decoded length
  task automatic add_code(input int code);
    int  l;
    bit  grow;
    code_q.push_back(code);
    bits_q.push_back(gen_bits);
    if (gen_literal) begin
      gen_total++;
      gen_prev    = code;
      gen_free    = FIRST_FREE;
      gen_literal = 0;
    end else begin
      l = (code == gen_free) ? len_of(gen_prev) + 1 : len_of(code);
      gen_total += l;
      str_len[gen_free] = len_of(gen_prev) + 1;
      grow     = (gen_free + 2) == (1 << gen_bits);
      gen_free = (gen_free + 1) & 'hfff;
      gen_prev = code;
      if (grow && gen_bits < int'(MAX_WIDTH)) gen_bits++;
      if (gen_free == int'(LAST_FREE)) begin
        gen_literal = 1;
        gen_bits    = START_WIDTH;
      end
    end
  endtask

  // code that must be rejected: non-literal first code or a code above next free
  task automatic add_bad();
    if (gen_literal)
      code_q.push_back($urandom_range(int'(FIRST_FREE), (1 << gen_bits) - 1));
    else
      code_q.push_back($urandom_range(gen_free + 1, (1 << gen_bits) - 1));
    bits_q.push_back(gen_bits);
  endtask

  function automatic int pick_code();
    int r;
    if (gen_literal) return $urandom_range(0, 255);
    r = $urandom_range(0, 99);
    if (r < 10) return gen_free;
    if (r < 15) return gen_free - 1;
    if (r < 40) return $urandom_range(0, 255);
    return $urandom_range(0, gen_free);
  endfunction

  // start a chunk, pack the codes msb first and send them
  task automatic ship(input int len, input bit longrun);
    longint acc;
    int     nacc;
    int     idx;
    logic [7:0] packed_q [$];
    drain();
    // top nibble is above the register and must be dropped
    apb_write(PADDR_W'(4 * REG_OUTPUT_LENGTH),
              {4'($urandom_range(0, 15)), len[LEN_W-1:0]});
    acc  = 0;
    nacc = 0;
    foreach (code_q[i]) begin
      acc  = (acc << bits_q[i]) | code_q[i];
      nacc += bits_q[i];
      while (nacc >= 8) begin
        packed_q.push_back(8'(acc >> (nacc - 8)));
        nacc -= 8;
        acc  &= (64'd1 << nacc) - 1;
      end
    end
    if (nacc > 0)
      packed_q.push_back(8'((acc << (8 - nacc)) | $urandom_range(0, (1 << (8 - nacc)) - 1)));
    idx = 0;
    foreach (packed_q[i]) begin
      if (longrun && idx == 8) long_stall_req = 1;
      if (longrun && idx == 20) begin
        // sender pause until the decoder has delivered everything
        byte_valid <= 0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
      end
      send_byte(packed_q[i], i == packed_q.size() - 1);
      idx++;
    end
    // trailing bytes after the end are swallowed
    if ($urandom_range(0, 3) == 0) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  task automatic random_chunk(input int ncodes, input bit longrun);
    int mode;
    int bad_at;
    int len;
    gen_reset();
    mode   = $urandom_range(0, 2);
    bad_at = (!longrun && $urandom_range(0, 6) == 0) ? $urandom_range(0, ncodes - 1) : -1;
    fast   = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < ncodes; i++) begin
      if (i == bad_at) begin
        add_bad();
        break;
      end
      add_code(pick_code());
    end
    if (longrun || mode == 0) len = gen_total;                       // ends exactly
    else if (mode == 1) len = gen_total + $urandom_range(1, 40);     // input runs short
    else len = (gen_total > 1) ? $urandom_range(1, gen_total - 1) : gen_total;
    ship(len, longrun);
  endtask

  initial begin
    rst            = 1;
    psel           = 0;
    penable        = 0;
    pwrite         = 0;
    paddr          = '0;
    pwdata         = '0;
    byte_valid     = 0;
    byte_item      = '0;
    fast           = 0;
    long_stall_req = 0;
    bytes_sent     = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // zero length out of reset completes on the first byte
    send_byte(8'hff, 0);
    drain();
    // write to an address past the register list is ignored, block stays done
    apb_write(3'd4, 32'h0000_0010);
    send_byte(8'h00, 1);
    drain();
    // explicit zero length
    apb_write(PADDR_W'(4 * REG_OUTPUT_LENGTH), 32'h0);
    send_byte(8'h5a, 1);
    drain();
    // lengths above the bound report overrun at once
    apb_write(PADDR_W'(4 * REG_OUTPUT_LENGTH), 32'h0800_0001);
    send_byte(8'ha5, 0);
    drain();
    apb_write(PADDR_W'(4 * REG_OUTPUT_LENGTH), 32'hffff_ffff);
    send_byte(8'h00, 0);

    // literal extremes, code equal to next free, then a code above next free
    gen_reset();
    add_code(255);
    add_code(0);
    add_code(gen_free);
    add_code(256);
    add_bad();
    ship(int'(MAX_LENGTH), 0);

    // non-literal first code
    gen_reset();
    add_bad();
    add_code(0);
    ship(10, 0);

    // completion exactly at the end, input ending early, overrun
    gen_reset();
    for (int i = 0; i < 6; i++) add_code(pick_code());
    ship(gen_total, 0);
    ship(gen_total + 3, 0);
    ship(gen_total - 1, 0);

    // random chunks
    bytes_sent = 0;
    while (bytes_sent < 30) random_chunk($urandom_range(3, 30), 0);

    // one chunk under a long receiver hold-off and a sender pause
    random_chunk(30, 1);
    random_chunk($urandom_range(3, 20), 0);

    drain();
    if (mismatches == 0 && pending == 0) begin
      $display("lzw_chunk_decoder_tb: PASS");
    end else begin
      $display("lzw_chunk_decoder_tb: FAIL");
    end
    $finish;
  end

endmodule
